// ----- src/park_distance_buzzer_controller_top_defines.svh -----
// ---------------------------------------------------------------------------
// park_distance_buzzer_controller_top_defines.svh
// Assertion macros shared by the buzzer controller RTL.
// ---------------------------------------------------------------------------
`ifndef PARK_DISTANCE_BUZZER_CONTROLLER_TOP_DEFINES_SVH
`define PARK_DISTANCE_BUZZER_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdbc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PDBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdbc: next-cycle check failed");

`endif

// ----- src/pdbc_pkg.sv -----
// ---------------------------------------------------------------------------
// pdbc_pkg
// Types, constants and register codes of the park distance buzzer controller.
// ---------------------------------------------------------------------------
package pdbc_pkg;

  localparam int unsigned ZoneW  = 3;
  localparam int unsigned DistW  = 8;
  localparam int unsigned CountW = 10;
  localparam int unsigned TickW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [ZoneW-1:0] ZONE_NEAREST = 3'd0;
  localparam logic [ZoneW-1:0] ZONE_NEAR    = 3'd1;
  localparam logic [ZoneW-1:0] ZONE_MID     = 3'd2;
  localparam logic [ZoneW-1:0] ZONE_FAR     = 3'd3;
  localparam logic [ZoneW-1:0] ZONE_MUTE    = 3'd4;

  // Upper band edges in cm, inclusive; FAR_HI_CM+1 .. MUTE_LO_CM-1 is the hold band.
  localparam logic [DistW-1:0] NEAREST_HI_CM = 8'd30;
  localparam logic [DistW-1:0] NEAR_HI_CM    = 8'd60;
  localparam logic [DistW-1:0] MID_HI_CM     = 8'd99;
  localparam logic [DistW-1:0] FAR_HI_CM     = 8'd139;
  localparam logic [DistW-1:0] MUTE_LO_CM    = 8'd150;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_STOP_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BEEP_ON    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_NEAR_OFF   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MID_OFF    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FAR_OFF    = 3'd4;

  localparam logic [CountW-1:0] STOP_LIMIT_RST = 10'd300;
  localparam logic [TickW-1:0]  BEEP_ON_RST    = 8'd5;
  localparam logic [TickW-1:0]  NEAR_OFF_RST   = 8'd10;
  localparam logic [TickW-1:0]  MID_OFF_RST    = 8'd60;
  localparam logic [TickW-1:0]  FAR_OFF_RST    = 8'd90;

  // Pattern timing registers.
  typedef struct packed {
    logic [TickW-1:0] beep_on;
    logic [TickW-1:0] near_off;
    logic [TickW-1:0] mid_off;
    logic [TickW-1:0] far_off;
  } pdbc_cfg_t;

  // What one sensor lane reports for the current tick.
  typedef struct packed {
    logic             valid;
    logic [ZoneW-1:0] zone;
  } pdbc_lane_t;

  // Combined zone and pattern restart request from the merge stage.
  typedef struct packed {
    logic [ZoneW-1:0] zone;
    logic             restart;
  } pdbc_zone_t;

endpackage

// ----- src/pdbc_lane.sv -----
// ---------------------------------------------------------------------------
// pdbc_lane
// One sensor lane: sorts a distance into a zone and keeps the last zone.
// ---------------------------------------------------------------------------
module pdbc_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [pdbc_pkg::DistW-1:0]    distance_i,
  output pdbc_pkg::pdbc_lane_t          lane_o
);

  logic [pdbc_pkg::ZoneW-1:0] zone_q;
  logic [pdbc_pkg::ZoneW-1:0] zone_d;
  logic                       dist_valid;

  assign dist_valid = (distance_i != '0);

  always_comb begin
    zone_d = zone_q;
    if (dist_valid) begin
      if (distance_i <= pdbc_pkg::NEAREST_HI_CM) begin
        zone_d = pdbc_pkg::ZONE_NEAREST;
      end else if (distance_i <= pdbc_pkg::NEAR_HI_CM) begin
        zone_d = pdbc_pkg::ZONE_NEAR;
      end else if (distance_i <= pdbc_pkg::MID_HI_CM) begin
        zone_d = pdbc_pkg::ZONE_MID;
      end else if (distance_i <= pdbc_pkg::FAR_HI_CM) begin
        zone_d = pdbc_pkg::ZONE_FAR;
      end else if (distance_i >= pdbc_pkg::MUTE_LO_CM) begin
        zone_d = pdbc_pkg::ZONE_MUTE;
      end
      // hold band: keep the old zone
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= pdbc_pkg::ZONE_MUTE;
    end else if (accept_i) begin
      zone_q <= zone_d;
    end
  end

  assign lane_o.valid = dist_valid;
  assign lane_o.zone  = zone_d;

endmodule

// ----- src/pdbc_merge.sv -----
// ---------------------------------------------------------------------------
// pdbc_merge
// Combines the two lanes: nearer zone, stop counter and invalid-sensor mute.
// ---------------------------------------------------------------------------
module pdbc_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  pdbc_pkg::pdbc_lane_t           left_i,
  input  pdbc_pkg::pdbc_lane_t           right_i,
  input  logic [pdbc_pkg::CountW-1:0]    stop_limit_i,
  output pdbc_pkg::pdbc_zone_t           zone_o
);

  logic [pdbc_pkg::ZoneW-1:0]  final_q, final_d;
  logic [pdbc_pkg::ZoneW-1:0]  prev_q, prev_d;
  logic [pdbc_pkg::CountW-1:0] count_q, count_d;
  logic [pdbc_pkg::ZoneW-1:0]  nearer;
  logic                        restart;

  assign nearer = (left_i.zone < right_i.zone) ? left_i.zone : right_i.zone;

  always_comb begin
    final_d = final_q;
    prev_d  = prev_q;
    count_d = count_q;
    restart = 1'b0;
    if (left_i.valid && right_i.valid) begin
      final_d = nearer;
      if (nearer != prev_q) begin
        count_d = '0;
        restart = 1'b1;
        prev_d  = nearer;
      end else if (count_q >= stop_limit_i) begin
        // stop counter expired: forced mute
        final_d = pdbc_pkg::ZONE_MUTE;
        restart = (nearer != pdbc_pkg::ZONE_MUTE);
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (final_q != pdbc_pkg::ZONE_MUTE) begin
      final_d = pdbc_pkg::ZONE_MUTE;
      prev_d  = pdbc_pkg::ZONE_MUTE;
      restart = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_q <= pdbc_pkg::ZONE_NEAREST;
      prev_q  <= pdbc_pkg::ZONE_MUTE;
      count_q <= '0;
    end else if (accept_i) begin
      final_q <= final_d;
      prev_q  <= prev_d;
      count_q <= count_d;
    end
  end

  assign zone_o.zone    = final_d;
  assign zone_o.restart = restart;

endmodule

// ----- src/pdbc_pattern.sv -----
// ---------------------------------------------------------------------------
// pdbc_pattern
// Beep pattern generator: continuous, on/off beeping or silence per zone.
// ---------------------------------------------------------------------------
module pdbc_pattern (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  pdbc_pkg::pdbc_zone_t  zone_i,
  input  pdbc_pkg::pdbc_cfg_t   cfg_i,
  output logic                  buzzer_o
);

  logic [pdbc_pkg::TickW-1:0] timer_q, timer_d;
  logic                       on_q, on_d;
  logic [pdbc_pkg::ZoneW-1:0] pzone_q, pzone_d;
  logic                       level_q, level_d;
  logic [pdbc_pkg::TickW-1:0] timer_e;
  logic                       on_e;
  logic [pdbc_pkg::TickW-1:0] limit;

  // A zone change restarts the phase before this tick's pattern step.
  assign timer_e = zone_i.restart ? '0 : timer_q;
  assign on_e    = zone_i.restart ? 1'b0 : on_q;

  always_comb begin
    pzone_d = pzone_q;
    level_d = level_q;
    timer_d = timer_e;
    on_d    = on_e;
    if ((timer_e == '0) && !on_e) begin
      pzone_d = zone_i.zone;
      level_d = 1'b0;
    end
    case (pzone_d)
      pdbc_pkg::ZONE_NEAR: limit = on_e ? cfg_i.beep_on : cfg_i.near_off;
      pdbc_pkg::ZONE_MID:  limit = on_e ? cfg_i.beep_on : cfg_i.mid_off;
      pdbc_pkg::ZONE_FAR:  limit = on_e ? cfg_i.beep_on : cfg_i.far_off;
      default:             limit = cfg_i.beep_on;
    endcase
    case (pzone_d)
      pdbc_pkg::ZONE_NEAREST: begin
        level_d = 1'b1;
        on_d    = 1'b1;
        timer_d = '0;
      end
      pdbc_pkg::ZONE_NEAR, pdbc_pkg::ZONE_MID, pdbc_pkg::ZONE_FAR: begin
        if (timer_e < limit) begin
          timer_d = timer_e + 1'b1;
        end else begin
          on_d    = !on_e;
          timer_d = '0;
          level_d = !on_e;
        end
      end
      default: begin
        level_d = 1'b0;
        on_d    = 1'b0;
        timer_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      on_q    <= 1'b0;
      pzone_q <= pdbc_pkg::ZONE_NEAREST;
      level_q <= 1'b0;
    end else if (accept_i) begin
      timer_q <= timer_d;
      on_q    <= on_d;
      pzone_q <= pzone_d;
      level_q <= level_d;
    end
  end

  assign buzzer_o = level_d;

endmodule

// ----- src/park_distance_buzzer_controller_top.sv -----
// ---------------------------------------------------------------------------
// park_distance_buzzer_controller_top
// Park distance buzzer controller: two sensor lanes, merge, beep pattern.
// ---------------------------------------------------------------------------
// One input transaction is one 10 ms tick carrying the left and right
// distances in cm (0 = sensor invalid); it yields exactly one result
// transaction with the buzzer level and the combined zone after that tick.
// The block takes one tick per clock cycle while in_stall_o is low: the
// whole tick update (both lane classifiers, the nearer-zone merge with
// its stop counter, and the pattern step) is combinational ahead of the
// state registers, and the result lands in an output register. A skid
// register behind it lets one more tick be taken while the output is
// stalled; in_stall_o rises only when both hold a result. Configuration
// writes are always ready and take effect on the next tick; index order is
// stop_limit, beep_on_ticks, near_off_ticks, mid_off_ticks, far_off_ticks,
// and writes to other indexes are dropped. Write configuration only while
// no result is pending.
// ---------------------------------------------------------------------------
`include "park_distance_buzzer_controller_top_defines.svh"

module park_distance_buzzer_controller_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pdbc_pkg::DistW-1:0]      left_distance_i,
  input  logic [pdbc_pkg::DistW-1:0]      right_distance_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            buzzer_on_o,
  output logic [pdbc_pkg::ZoneW-1:0]      combined_zone_o,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pdbc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pdbc_pkg::CfgDataW-1:0]   cfg_data_i
);

  // configuration registers
  logic [pdbc_pkg::CountW-1:0] stop_limit_q;
  pdbc_pkg::pdbc_cfg_t         cfg_q;
  logic                        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_limit_q   <= pdbc_pkg::STOP_LIMIT_RST;
      cfg_q.beep_on  <= pdbc_pkg::BEEP_ON_RST;
      cfg_q.near_off <= pdbc_pkg::NEAR_OFF_RST;
      cfg_q.mid_off  <= pdbc_pkg::MID_OFF_RST;
      cfg_q.far_off  <= pdbc_pkg::FAR_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        pdbc_pkg::CFG_STOP_LIMIT: stop_limit_q   <= cfg_data_i;
        pdbc_pkg::CFG_BEEP_ON:    cfg_q.beep_on  <= cfg_data_i[pdbc_pkg::TickW-1:0];
        pdbc_pkg::CFG_NEAR_OFF:   cfg_q.near_off <= cfg_data_i[pdbc_pkg::TickW-1:0];
        pdbc_pkg::CFG_MID_OFF:    cfg_q.mid_off  <= cfg_data_i[pdbc_pkg::TickW-1:0];
        pdbc_pkg::CFG_FAR_OFF:    cfg_q.far_off  <= cfg_data_i[pdbc_pkg::TickW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // handshake: stall only while the skid register is occupied
  logic out_valid_q, skid_valid_q;
  logic accept, take;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = out_valid_q && !out_stall_i;

  // sensor lanes
  pdbc_pkg::pdbc_lane_t left_lane, right_lane;
  pdbc_pkg::pdbc_zone_t zone;
  logic                 buzzer;

  pdbc_lane u_lane_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .distance_i (left_distance_i),
    .lane_o     (left_lane)
  );

  pdbc_lane u_lane_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .distance_i (right_distance_i),
    .lane_o     (right_lane)
  );

  // merge: nearer zone, stop counter, mute on invalid sensor
  pdbc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .left_i       (left_lane),
    .right_i      (right_lane),
    .stop_limit_i (stop_limit_q),
    .zone_o       (zone)
  );

  // beep pattern
  pdbc_pattern u_pattern (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .zone_i   (zone),
    .cfg_i    (cfg_q),
    .buzzer_o (buzzer)
  );

  // output register and skid register
  logic                       out_buzzer_q, skid_buzzer_q;
  logic [pdbc_pkg::ZoneW-1:0] out_zone_q, skid_zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (out_valid_q && !take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (out_valid_q && !take) begin
        skid_buzzer_q <= buzzer;
        skid_zone_q   <= zone.zone;
      end else begin
        out_buzzer_q <= buzzer;
        out_zone_q   <= zone.zone;
      end
    end else if (take && skid_valid_q) begin
      out_buzzer_q <= skid_buzzer_q;
      out_zone_q   <= skid_zone_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign buzzer_on_o     = out_buzzer_q;
  assign combined_zone_o = out_zone_q;

  // skid only ever holds the younger of two pending results
  `PDBC_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // a tick arriving against a stalled output parks in the skid register
  `PDBC_ASSERT_NXT(a_stall_fills_skid, clk_i, rst_ni, accept && out_valid_q && out_stall_i,
                   skid_valid_q && out_valid_q)
  // draining the skid moves its result forward and frees the input
  `PDBC_ASSERT_NXT(a_skid_drains, clk_i, rst_ni, take && skid_valid_q,
                   out_valid_q && !skid_valid_q)

endmodule
